[rtl/prlm_pkg.sv]
// Shared types and constants for the parallel rank layout mapper.
// Holds the request/result payloads, the layout bundle and the reciprocal table.
// No dependencies.
package prlm_pkg;

  localparam int MAX_AXIS_SIZE = 64;
  localparam int NUM_AXES      = 3;
  localparam int RANK_W        = 18;
  localparam int COORD_W       = 6;
  localparam int GROUP_W       = 12;
  localparam int SIZE_W        = 7;
  localparam int STRIDE_W      = 13;
  localparam int AXIS_W        = 2;
  localparam int RCP_W         = 26;
  localparam int RCP_SHIFT     = 25;
  localparam int RCP_SCALE     = 2 ** RCP_SHIFT;
  localparam int RCP_IDX_W     = $clog2(MAX_AXIS_SIZE);
  localparam int PROD_W        = RANK_W + RCP_W;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 7;

  typedef enum logic [1:0] {
    MODE_RANK    = 2'd0,
    MODE_COORD   = 2'd1,
    MODE_GROUP   = 2'd2,
    MODE_MEMBERS = 2'd3
  } mode_t;

  typedef logic [AXIS_W-1:0] axis_t;

  localparam axis_t AXIS_DATA   = 2'd0;
  localparam axis_t AXIS_TENSOR = 2'd1;
  localparam axis_t AXIS_PIPE   = 2'd2;
  localparam axis_t AXIS_BAD    = 2'd3;

  typedef struct packed {
    mode_t                mode;
    logic [COORD_W-1:0]   coord_data;
    logic [COORD_W-1:0]   coord_tensor;
    logic [COORD_W-1:0]   coord_pipeline;
    logic [RANK_W-1:0]    flat_rank;
    logic [AXIS_W-1:0]    target_axis;
  } prlm_in_t;

  typedef struct packed {
    logic [RANK_W-1:0]    rank_out;
    logic [COORD_W-1:0]   data_out;
    logic [COORD_W-1:0]   tensor_out;
    logic [COORD_W-1:0]   pipeline_out;
    logic [GROUP_W-1:0]   group_out;
    logic                 last;
  } prlm_out_t;

  // ord, psz and rcp are indexed by stride position; esz and st by axis
  typedef struct packed {
    logic [NUM_AXES-1:0][AXIS_W-1:0]   ord;
    logic [NUM_AXES-1:0][SIZE_W-1:0]   esz;
    logic [NUM_AXES-1:0][STRIDE_W-1:0] st;
    logic [NUM_AXES-1:0][SIZE_W-1:0]   psz;
    logic [NUM_AXES-1:0][RCP_W-1:0]    rcp;
  } layout_t;

  typedef struct packed {
    mode_t                            mode;
    logic [NUM_AXES-1:0][COORD_W-1:0] coord;
    logic [RANK_W-1:0]                rank;
    axis_t                            tgt;
    logic                             last;
  } sub_t;

  // floor(x / s) == (x * RCP_TABLE[s-1]) >> RCP_SHIFT for every 18-bit x, s in 1..64
  localparam logic [RCP_W-1:0] RCP_TABLE [MAX_AXIS_SIZE] = '{
    RCP_W'(RCP_SCALE /  1 + 1), RCP_W'(RCP_SCALE /  2 + 1),
    RCP_W'(RCP_SCALE /  3 + 1), RCP_W'(RCP_SCALE /  4 + 1),
    RCP_W'(RCP_SCALE /  5 + 1), RCP_W'(RCP_SCALE /  6 + 1),
    RCP_W'(RCP_SCALE /  7 + 1), RCP_W'(RCP_SCALE /  8 + 1),
    RCP_W'(RCP_SCALE /  9 + 1), RCP_W'(RCP_SCALE / 10 + 1),
    RCP_W'(RCP_SCALE / 11 + 1), RCP_W'(RCP_SCALE / 12 + 1),
    RCP_W'(RCP_SCALE / 13 + 1), RCP_W'(RCP_SCALE / 14 + 1),
    RCP_W'(RCP_SCALE / 15 + 1), RCP_W'(RCP_SCALE / 16 + 1),
    RCP_W'(RCP_SCALE / 17 + 1), RCP_W'(RCP_SCALE / 18 + 1),
    RCP_W'(RCP_SCALE / 19 + 1), RCP_W'(RCP_SCALE / 20 + 1),
    RCP_W'(RCP_SCALE / 21 + 1), RCP_W'(RCP_SCALE / 22 + 1),
    RCP_W'(RCP_SCALE / 23 + 1), RCP_W'(RCP_SCALE / 24 + 1),
    RCP_W'(RCP_SCALE / 25 + 1), RCP_W'(RCP_SCALE / 26 + 1),
    RCP_W'(RCP_SCALE / 27 + 1), RCP_W'(RCP_SCALE / 28 + 1),
    RCP_W'(RCP_SCALE / 29 + 1), RCP_W'(RCP_SCALE / 30 + 1),
    RCP_W'(RCP_SCALE / 31 + 1), RCP_W'(RCP_SCALE / 32 + 1),
    RCP_W'(RCP_SCALE / 33 + 1), RCP_W'(RCP_SCALE / 34 + 1),
    RCP_W'(RCP_SCALE / 35 + 1), RCP_W'(RCP_SCALE / 36 + 1),
    RCP_W'(RCP_SCALE / 37 + 1), RCP_W'(RCP_SCALE / 38 + 1),
    RCP_W'(RCP_SCALE / 39 + 1), RCP_W'(RCP_SCALE / 40 + 1),
    RCP_W'(RCP_SCALE / 41 + 1), RCP_W'(RCP_SCALE / 42 + 1),
    RCP_W'(RCP_SCALE / 43 + 1), RCP_W'(RCP_SCALE / 44 + 1),
    RCP_W'(RCP_SCALE / 45 + 1), RCP_W'(RCP_SCALE / 46 + 1),
    RCP_W'(RCP_SCALE / 47 + 1), RCP_W'(RCP_SCALE / 48 + 1),
    RCP_W'(RCP_SCALE / 49 + 1), RCP_W'(RCP_SCALE / 50 + 1),
    RCP_W'(RCP_SCALE / 51 + 1), RCP_W'(RCP_SCALE / 52 + 1),
    RCP_W'(RCP_SCALE / 53 + 1), RCP_W'(RCP_SCALE / 54 + 1),
    RCP_W'(RCP_SCALE / 55 + 1), RCP_W'(RCP_SCALE / 56 + 1),
    RCP_W'(RCP_SCALE / 57 + 1), RCP_W'(RCP_SCALE / 58 + 1),
    RCP_W'(RCP_SCALE / 59 + 1), RCP_W'(RCP_SCALE / 60 + 1),
    RCP_W'(RCP_SCALE / 61 + 1), RCP_W'(RCP_SCALE / 62 + 1),
    RCP_W'(RCP_SCALE / 63 + 1), RCP_W'(RCP_SCALE / 64 + 1)
  };

endpackage

[rtl/prlm_cfg.sv]
// Configuration registers and registered layout derivation (order, sizes,
// strides, reciprocals) for the rank layout mapper. Depends on prlm_pkg.
module prlm_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [prlm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [prlm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output prlm_pkg::layout_t                layout
);
  import prlm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_THIRD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_DATA    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_TENSOR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_PIPE    = 3'd5;

  logic [NUM_AXES-1:0][AXIS_W-1:0] order_r;
  logic [NUM_AXES-1:0][SIZE_W-1:0] size_r;
  layout_t                         layout_r;
  layout_t                         layout_nxt;

  assign cfg_ready = 1'b1;
  assign layout    = layout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= {AXIS_PIPE, AXIS_TENSOR, AXIS_DATA};
      size_r  <= {NUM_AXES{SIZE_W'(1)}};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ORDER_FIRST:  order_r[0]         <= cfg_wdata[AXIS_W-1:0];
        REG_ORDER_SECOND: order_r[1]         <= cfg_wdata[AXIS_W-1:0];
        REG_ORDER_THIRD:  order_r[2]         <= cfg_wdata[AXIS_W-1:0];
        REG_SIZE_DATA:    size_r[AXIS_DATA]   <= cfg_wdata;
        REG_SIZE_TENSOR:  size_r[AXIS_TENSOR] <= cfg_wdata;
        REG_SIZE_PIPE:    size_r[AXIS_PIPE]   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [3:0]                        seen;
    logic [NUM_AXES-1:0][AXIS_W-1:0]   ord;
    logic [NUM_AXES-1:0][SIZE_W-1:0]   esz;
    logic [NUM_AXES-1:0][SIZE_W-1:0]   psz;
    logic [NUM_AXES-1:0][STRIDE_W-1:0] pst;
    logic [2*SIZE_W-1:0]               prod01;
    seen = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      seen[order_r[i]] = 1'b1;
    end
    // fall back to the natural order unless the order is a permutation
    ord = (seen == 4'b0111) ? order_r : {AXIS_PIPE, AXIS_TENSOR, AXIS_DATA};
    for (int a = 0; a < NUM_AXES; a++) begin
      if (size_r[a] == '0) begin
        esz[a] = SIZE_W'(1);
      end else if (size_r[a] > SIZE_W'(MAX_AXIS_SIZE)) begin
        esz[a] = SIZE_W'(MAX_AXIS_SIZE);
      end else begin
        esz[a] = size_r[a];
      end
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      psz[i] = esz[ord[i]];
    end
    prod01 = (2*SIZE_W)'(psz[0]) * (2*SIZE_W)'(psz[1]);
    pst[0] = STRIDE_W'(1);
    pst[1] = STRIDE_W'(psz[0]);
    pst[2] = prod01[STRIDE_W-1:0];
    layout_nxt.ord = ord;
    layout_nxt.esz = esz;
    layout_nxt.psz = psz;
    layout_nxt.st  = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      layout_nxt.st[ord[i]] = pst[i];
      layout_nxt.rcp[i]     = RCP_TABLE[RCP_IDX_W'(psz[i] - SIZE_W'(1))];
    end
  end

  always_ff @(posedge clk) begin
    layout_r <= layout_nxt;
  end

endmodule

[rtl/prlm_seq.sv]
// Request holding stage and group-member sequencer of the rank layout mapper.
// Expands a member-list request into one pipeline entry per member. Depends on prlm_pkg.
module prlm_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  prlm_pkg::prlm_in_t  in_data,
  input  prlm_pkg::layout_t   layout,
  output logic                sub_valid,
  input  logic                sub_ready,
  output prlm_pkg::sub_t      sub
);
  import prlm_pkg::*;

  logic               busy_r;
  prlm_in_t           item_r;
  logic [COORD_W-1:0] cnt_r;
  axis_t              tgt;
  logic [SIZE_W-1:0]  count;
  logic               final_sub;
  logic               issue;
  logic               accept;

  assign tgt       = (item_r.target_axis == AXIS_BAD) ? AXIS_PIPE : item_r.target_axis;
  assign count     = layout.esz[tgt];
  assign final_sub = (item_r.mode != MODE_MEMBERS) || ({1'b0, cnt_r} == count - SIZE_W'(1));
  assign issue     = busy_r && sub_ready;
  assign in_stall  = busy_r && !(sub_ready && final_sub);
  assign accept    = in_valid && !in_stall;
  assign sub_valid = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (accept) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (issue) begin
      if (final_sub) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + COORD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
  end

  always_comb begin
    sub.mode  = item_r.mode;
    sub.coord = {item_r.coord_pipeline, item_r.coord_tensor, item_r.coord_data};
    if (item_r.mode == MODE_MEMBERS) begin
      sub.coord[tgt] = cnt_r;
    end
    sub.rank = item_r.flat_rank;
    sub.tgt  = tgt;
    sub.last = final_sub;
  end

endmodule

[rtl/prlm_pipe.sv]
// Six-stage arithmetic pipeline of the rank layout mapper: stride products,
// group id and three chained reciprocal divisions, ending in the result register.
// Depends on prlm_pkg.
module prlm_pipe (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 sub_valid,
  output logic                 sub_ready,
  input  prlm_pkg::sub_t       sub,
  input  prlm_pkg::layout_t    layout,
  output logic                 out_valid,
  input  logic                 out_stall,
  output prlm_pkg::prlm_out_t  out_data
);
  import prlm_pkg::*;

  localparam int MPROD_W = COORD_W + STRIDE_W;
  localparam int GB_W    = COORD_W + SIZE_W;
  localparam int QS_W    = RANK_W + SIZE_W;
  localparam int STAGES  = 6;
  localparam int MIDS    = 4;

  typedef struct packed {
    mode_t                            mode;
    logic                             last;
    logic [NUM_AXES-1:0][MPROD_W-1:0] mprod;
    logic [COORD_W-1:0]               ga;
    logic [GB_W-1:0]                  gb;
    logic [PROD_W-1:0]                prod;
    logic [RANK_W-1:0]                rank;
  } s1_t;

  typedef struct packed {
    mode_t                            mode;
    logic                             last;
    logic [RANK_W-1:0]                rank_sum;
    logic [GROUP_W-1:0]               gid;
    logic [NUM_AXES-1:0][COORD_W-1:0] rem;
    logic [RANK_W-1:0]                quo;
    logic [PROD_W-1:0]                prod;
  } mid_t;

  function automatic logic [COORD_W-1:0] rem_of(input logic [RANK_W-1:0] x,
                                                input logic [RANK_W-1:0] q,
                                                input logic [SIZE_W-1:0] s);
    logic [QS_W-1:0] qs;
    qs = QS_W'(q) * QS_W'(s);
    return COORD_W'(x - qs[RANK_W-1:0]);
  endfunction

  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] rdy;
  s1_t               s1_r;
  s1_t               s1_nxt;
  mid_t              mid_r   [MIDS];
  mid_t              mid_nxt [MIDS];
  prlm_out_t         out_r;
  prlm_out_t         out_nxt;

  always_comb begin
    rdy[STAGES-1] = !vld_r[STAGES-1] || !out_stall;
    for (int k = STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign sub_ready = rdy[0];
  assign out_valid = vld_r[STAGES-1];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= sub_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // stage 1: stride products, group terms, first reciprocal product
  always_comb begin
    axis_t ga_ax;
    axis_t gb_ax;
    if (layout.ord[2] != sub.tgt) begin
      ga_ax = layout.ord[2];
      gb_ax = (layout.ord[1] != sub.tgt) ? layout.ord[1] : layout.ord[0];
    end else begin
      ga_ax = layout.ord[1];
      gb_ax = layout.ord[0];
    end
    s1_nxt.mode = sub.mode;
    s1_nxt.last = sub.last;
    for (int a = 0; a < NUM_AXES; a++) begin
      s1_nxt.mprod[a] = MPROD_W'(sub.coord[a]) * MPROD_W'(layout.st[a]);
    end
    s1_nxt.ga   = sub.coord[ga_ax];
    s1_nxt.gb   = GB_W'(sub.coord[gb_ax]) * GB_W'(layout.esz[ga_ax]);
    s1_nxt.prod = PROD_W'(sub.rank) * PROD_W'(layout.rcp[0]);
    s1_nxt.rank = sub.rank;
  end

  // stages 2 to 5: sums, then alternate quotient/remainder and next reciprocal product
  always_comb begin
    logic [RANK_W-1:0] q;
    mid_nxt[0].mode     = s1_r.mode;
    mid_nxt[0].last     = s1_r.last;
    mid_nxt[0].rank_sum = RANK_W'(s1_r.mprod[0] + s1_r.mprod[1] + s1_r.mprod[2]);
    mid_nxt[0].gid      = GROUP_W'(GB_W'(s1_r.ga) + s1_r.gb);
    q                   = s1_r.prod[RCP_SHIFT +: RANK_W];
    mid_nxt[0].quo      = q;
    mid_nxt[0].rem      = '0;
    mid_nxt[0].rem[0]   = rem_of(s1_r.rank, q, layout.psz[0]);
    mid_nxt[0].prod     = s1_r.prod;

    mid_nxt[1]      = mid_r[0];
    mid_nxt[1].prod = PROD_W'(mid_r[0].quo) * PROD_W'(layout.rcp[1]);

    mid_nxt[2]        = mid_r[1];
    mid_nxt[2].quo    = mid_r[1].prod[RCP_SHIFT +: RANK_W];
    mid_nxt[2].rem[1] = rem_of(mid_r[1].quo, mid_r[1].prod[RCP_SHIFT +: RANK_W],
                               layout.psz[1]);

    mid_nxt[3]      = mid_r[2];
    mid_nxt[3].prod = PROD_W'(mid_r[2].quo) * PROD_W'(layout.rcp[2]);
  end

  // stage 6: last remainder, map positions back to axes, zero unused fields
  always_comb begin
    logic [NUM_AXES-1:0][COORD_W-1:0] rem;
    logic [NUM_AXES-1:0][COORD_W-1:0] axc;
    rem    = mid_r[3].rem;
    rem[2] = rem_of(mid_r[3].quo, mid_r[3].prod[RCP_SHIFT +: RANK_W], layout.psz[2]);
    axc    = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      axc[layout.ord[i]] = rem[i];
    end
    out_nxt = '0;
    out_nxt.last = mid_r[3].last;
    unique case (mid_r[3].mode)
      MODE_RANK, MODE_MEMBERS: out_nxt.rank_out = mid_r[3].rank_sum;
      MODE_COORD: begin
        out_nxt.data_out     = axc[AXIS_DATA];
        out_nxt.tensor_out   = axc[AXIS_TENSOR];
        out_nxt.pipeline_out = axc[AXIS_PIPE];
      end
      MODE_GROUP: out_nxt.group_out = mid_r[3].gid;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_r <= s1_nxt;
    end
    for (int k = 0; k < MIDS; k++) begin
      if (rdy[k+1]) begin
        mid_r[k] <= mid_nxt[k];
      end
    end
    if (rdy[STAGES-1]) begin
      out_r <= out_nxt;
    end
  end

endmodule

[rtl/parallel_rank_layout_mapper.sv]
// Top level of the parallel rank layout mapper: converts between flat worker
// ranks and data/tensor/pipeline coordinates. Depends on prlm_pkg and the prlm_* modules.
//
// Usage:
//   cfg_*  : register writes (order_first, order_second, order_third, size_data,
//            size_tensor, size_pipeline at indexes 0..5); cfg_ready is always high, a
//            write goes to the config register, then to layout_r. Write only while idle.
//   in_*   : one request per accepted cycle (in_valid high, in_stall low).
//   out_*  : results, taken when out_valid is high and out_stall is low.
// Path: an accepted request is held in the sequencer, then passes stages 1 to 6.
// Throughput: rank, coordinate and group-id requests each become one pipeline
//   entry; a member-list request becomes one entry per group member (1 to 64),
//   and the member sequencer issues one pipeline entry per cycle unless stage 1 stalls.
// The six pipeline stages each hold a valid bit; a stalled result holds in the
//   output register while earlier stages keep filling their empty slots. in_stall
//   rises while a held member list is still being issued or stage 1 cannot accept.
// Reset clears all valid bits, the sequencer and the registers to their
//   defaults (natural order, every size one).
module parallel_rank_layout_mapper (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [prlm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [prlm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  prlm_pkg::prlm_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output prlm_pkg::prlm_out_t              out_data
);
  import prlm_pkg::*;

  layout_t layout;
  sub_t    sub;
  logic    sub_valid;
  logic    sub_ready;

  prlm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .layout    (layout)
  );

  prlm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .layout    (layout),
    .sub_valid (sub_valid),
    .sub_ready (sub_ready),
    .sub       (sub)
  );

  prlm_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .sub_valid (sub_valid),
    .sub_ready (sub_ready),
    .sub       (sub),
    .layout    (layout),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
